// ===== hdl/tlcs_pkg.sv =====
package tlcs_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 256;
	localparam int unsigned MAX_HEIGHT_DEF = 256;
	localparam int unsigned MAX_RADIUS_DEF = 15;

	localparam logic [1:0] CMD_DRAW  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

endpackage

// ===== hdl/thick_line_circle_stamp_raster.sv =====
// Channel  | Handshake               | Beat content
// ---------+-------------------------+-----------------------------------------------
// in       | in_valid / in_stall     | cmd, start_x, start_y, end_x, end_y,
//          |                         | brush_radius, paint_value
// out      | out_valid / out_stall   | pixel_value (one beat per read command)
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data (0 width, 1 height)
//
// A read passes address, memory read and output register, waiting in ST_RDATA while the
//   output register holds a stalled beat. A clear zeroes all MAX_WIDTH*MAX_HEIGHT store
//   entries, one store entry per cycle through the single write port. A draw stamps
//   steps+1 discs, steps = max(|dx|,|dy|): the stamp sequencer visits one disc offset per
//   cycle and the store takes one write per cycle. Reset starts the same clearing pass;
//   in_stall stays high. in_stall is high whenever a command is in progress; a finished
//   read waits in the output register while the next command is taken.
module thick_line_circle_stamp_raster #(
	parameter int unsigned MAX_WIDTH  = tlcs_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = tlcs_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned MAX_RADIUS = tlcs_pkg::MAX_RADIUS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] start_x,
	input  logic [7:0] start_y,
	input  logic [7:0] end_x,
	input  logic [7:0] end_y,
	input  logic [3:0] brush_radius,
	input  logic [7:0] paint_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pixel_value,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CWX   = $clog2(MAX_WIDTH);
	localparam int unsigned CWY   = $clog2(MAX_HEIGHT);
	localparam int unsigned CW    = (CWX > CWY) ? CWX : CWY;
	localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
	localparam int unsigned OW    = RW + 1;
	localparam int unsigned PW    = CW + RW + 2;
	localparam int unsigned SQW   = 2 * RW + 3;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_POINT = 3'd3;
	localparam logic [2:0] ST_STAMP = 3'd4;
	localparam logic [2:0] ST_RADDR = 3'd5;
	localparam logic [2:0] ST_RDATA = 3'd6;

	logic [2:0] state_q;
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;

	// pixel store, y*W+x with W the active width
	logic [7:0] mem [DEPTH];
	logic [AW:0] clr_cnt_q;

	// segment setup
	logic [CW-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [RW-1:0] r_q;
	logic [7:0]    val_q;
	logic [7:0]    rx_q, ry_q;
	logic          rin_q;
	logic [CW-1:0] adx_q, ady_q, steps_q, s_q;
	logic          xneg_q, yneg_q;
	logic [CW-1:0] qx_q, qy_q, remx_q, remy_q;
	logic signed [PW-1:0] cx_q, cy_q;
	logic signed [OW-1:0] ox_q, oy_q;
	logic [SQW-1:0] rsq_q;

	// stamp write stage
	logic          wr_s1;
	logic [CW-1:0] wx_s1, wy_s1;

	logic [7:0] rd_data_s2;
	logic       out_valid_q;
	logic [7:0] pixel_q;

	logic accept;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign pixel_value = pixel_q;

	// clamp endpoints to the active raster and the radius to MAX_RADIUS
	logic [CW-1:0] sx_c, sy_c, ex_c, ey_c;
	logic [RW-1:0] r_c;
	always_comb begin
		sx_c = (32'(start_x) >= 32'(w_q)) ? CW'(w_q - WW'(1)) : CW'(start_x);
		ex_c = (32'(end_x)   >= 32'(w_q)) ? CW'(w_q - WW'(1)) : CW'(end_x);
		sy_c = (32'(start_y) >= 32'(h_q)) ? CW'(h_q - HW'(1)) : CW'(start_y);
		ey_c = (32'(end_y)   >= 32'(h_q)) ? CW'(h_q - HW'(1)) : CW'(end_y);
		r_c  = (32'(brush_radius) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(brush_radius);
	end

	// deltas, signs and step count
	logic signed [CW:0] dx_c, dy_c;
	logic [CW-1:0] adx_c, ady_c;
	always_comb begin
		dx_c  = $signed({1'b0, x1_q}) - $signed({1'b0, x0_q});
		dy_c  = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
		adx_c = dx_c[CW] ? CW'(-dx_c) : CW'(dx_c);
		ady_c = dy_c[CW] ? CW'(-dy_c) : CW'(dy_c);
	end

	// next minor-axis quotient: one compare and subtract per step
	logic [CW:0] sumx_c, sumy_c;
	logic        carx_c, cary_c;
	always_comb begin
		sumx_c = {1'b0, remx_q} + {1'b0, adx_q};
		sumy_c = {1'b0, remy_q} + {1'b0, ady_q};
		carx_c = (sumx_c >= {1'b0, steps_q});
		cary_c = (sumy_c >= {1'b0, steps_q});
	end

	// disc test and raster bounds at the current offset
	logic signed [SQW-1:0] oxe_c, oye_c;
	logic [SQW-1:0] dist_c;
	logic signed [PW-1:0] px_c, py_c;
	logic hit_c, ox_last_c, oy_last_c;
	always_comb begin
		oxe_c  = SQW'(ox_q);
		oye_c  = SQW'(oy_q);
		dist_c = SQW'(oxe_c * oxe_c) + SQW'(oye_c * oye_c);
		px_c   = cx_q + PW'(ox_q);
		py_c   = cy_q + PW'(oy_q);
		hit_c  = (dist_c <= rsq_q) && !px_c[PW-1] && !py_c[PW-1]
			&& (px_c < $signed(PW'(w_q))) && (py_c < $signed(PW'(h_q)));
		ox_last_c = (ox_q == $signed({1'b0, r_q}));
		oy_last_c = (oy_q == $signed({1'b0, r_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(MAX_WIDTH);
			h_q <= HW'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			// zero acts as one, anything above the maximum acts as the maximum
			unique case (cfg_index)
				tlcs_pkg::REG_WIDTH: begin
					if (cfg_data == 9'd0)
						w_q <= WW'(1);
					else if (32'(cfg_data) > 32'(MAX_WIDTH))
						w_q <= WW'(MAX_WIDTH);
					else
						w_q <= WW'(cfg_data);
				end
				tlcs_pkg::REG_HEIGHT: begin
					if (cfg_data == 9'd0)
						h_q <= HW'(1);
					else if (32'(cfg_data) > 32'(MAX_HEIGHT))
						h_q <= HW'(MAX_HEIGHT);
					else
						h_q <= HW'(cfg_data);
				end
				default: ;
			endcase
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// hand the covered pixel to the write stage
			wr_s1 <= (state_q == ST_STAMP) && hit_c;
			// load a finished read once the output register is free, drop a taken beat
			if (state_q == ST_RDATA && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							tlcs_pkg::CMD_DRAW:  state_q <= ST_SETUP;
							tlcs_pkg::CMD_READ:  state_q <= ST_RADDR;
							tlcs_pkg::CMD_CLEAR: begin
								state_q   <= ST_CLEAR;
								clr_cnt_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + (AW+1)'(1);
					if (clr_cnt_q == (AW+1)'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_SETUP: state_q <= ST_POINT;
				ST_POINT: state_q <= ST_STAMP;
				ST_STAMP: begin
					if (ox_last_c && oy_last_c) begin
						state_q <= (s_q == steps_q) ? ST_IDLE : ST_POINT;
					end
				end
				ST_RADDR: state_q <= ST_RDATA;
				ST_RDATA: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q  <= sx_c;
			y0_q  <= sy_c;
			x1_q  <= ex_c;
			y1_q  <= ey_c;
			r_q   <= r_c;
			val_q <= paint_value;
			rx_q  <= start_x;
			ry_q  <= start_y;
			rin_q <= (32'(start_x) < 32'(w_q)) && (32'(start_y) < 32'(h_q));
		end
		if (state_q == ST_SETUP) begin
			adx_q   <= adx_c;
			ady_q   <= ady_c;
			xneg_q  <= dx_c[CW];
			yneg_q  <= dy_c[CW];
			steps_q <= (adx_c > ady_c) ? adx_c : ady_c;
			s_q     <= '0;
			qx_q    <= '0;
			qy_q    <= '0;
			remx_q  <= '0;
			remy_q  <= '0;
			rsq_q   <= SQW'(r_q) * SQW'(r_q);
		end
		if (state_q == ST_POINT) begin
			cx_q <= xneg_q ? $signed(PW'(x0_q)) - $signed(PW'(qx_q))
				: $signed(PW'(x0_q)) + $signed(PW'(qx_q));
			cy_q <= yneg_q ? $signed(PW'(y0_q)) - $signed(PW'(qy_q))
				: $signed(PW'(y0_q)) + $signed(PW'(qy_q));
			ox_q <= -$signed({1'b0, r_q});
			oy_q <= -$signed({1'b0, r_q});
		end
		if (state_q == ST_STAMP) begin
			wx_s1 <= CW'(px_c);
			wy_s1 <= CW'(py_c);
			if (ox_last_c) begin
				ox_q <= -$signed({1'b0, r_q});
				oy_q <= oy_q + OW'(1);
			end else begin
				ox_q <= ox_q + OW'(1);
			end
			if (ox_last_c && oy_last_c) begin
				// advance along the segment
				s_q    <= s_q + CW'(1);
				qx_q   <= carx_c ? qx_q + CW'(1) : qx_q;
				qy_q   <= cary_c ? qy_q + CW'(1) : qy_q;
				remx_q <= carx_c ? CW'(sumx_c - {1'b0, steps_q}) : CW'(sumx_c);
				remy_q <= cary_c ? CW'(sumy_c - {1'b0, steps_q}) : CW'(sumy_c);
			end
		end
		if (state_q == ST_RDATA && (!out_valid_q || !out_stall))
			pixel_q <= rin_q ? rd_data_s2 : 8'd0;
	end

	// store: one write port, one registered read port
	logic [AW-1:0] rd_addr_c, wr_addr_c;
	assign rd_addr_c = AW'(AW'(ry_q) * AW'(w_q)) + AW'(rx_q);
	assign wr_addr_c = AW'(AW'(wy_s1) * AW'(w_q)) + AW'(wx_s1);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			mem[clr_cnt_q[AW-1:0]] <= 8'd0;
		else if (wr_s1)
			mem[wr_addr_c] <= val_q;
		rd_data_s2 <= mem[rd_addr_c];
	end

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RDATA))
		else $error("result beat raised outside a read");
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !wr_s1)
		else $error("stamp write overlaps clearing pass");
	a_write_in_raster: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (32'(wx_s1) < 32'(w_q)) && (32'(wy_s1) < 32'(h_q)))
		else $error("stamp write outside active raster");

endmodule

// ===== bench/tb.sv =====
module tb;

	// cmd 3 is not decoded by the block; the spare register index is ignored
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int MAXW = 256;
	localparam int MAXH = 256;
	localparam int MAXR = 15;
	localparam int CYCLE_LIMIT = 8000000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] cmd;
	logic [7:0] start_x, start_y, end_x, end_y;
	logic [3:0] brush_radius;
	logic [7:0] paint_value;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] pixel_value;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	thick_line_circle_stamp_raster u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y),
		.brush_radius(brush_radius), .paint_value(paint_value),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_value(pixel_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow raster and active layout, updated when a beat is accepted
	logic [7:0] shadow_img [0:MAXW*MAXH-1];
	int         act_w, act_h;
	logic [7:0] pending_pixels [$];

	int  fail_cnt;
	int  cycle_cnt;
	int  send_gap_pct;
	int  recv_stall_pct;
	int  hold_req;
	int  hold_left;
	int  last_x, last_y;

	initial begin
		clk = 1'b0;
	end
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Global watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver side: random stall, or a long counted hold-off on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Compare every accepted output beat with the oldest pending read
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel_value beat, actual %0d", $time, pixel_value);
				fail_cnt++;
			end else begin
				if (pixel_value !== pending_pixels[0]) begin
					$display("%0t: pixel_value expected %0d actual %0d",
						$time, pending_pixels[0], pixel_value);
					fail_cnt++;
				end
				void'(pending_pixels.pop_front());
			end
		end
	end

	function automatic int fit_dim(logic [8:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic int edge_clamp(logic [7:0] v, int dim);
		if (int'(v) >= dim) return dim - 1;
		return int'(v);
	endfunction

	task automatic wipe_shadow();
		for (int i = 0; i < MAXW*MAXH; i++) shadow_img[i] = 8'd0;
	endtask

	// Queue one expected read beat at the tail
	task automatic expect_pixel(logic [7:0] v);
		pending_pixels = {pending_pixels, v};
	endtask

	task automatic stamp_disc(int cx, int cy, int r, logic [7:0] val);
		int px, py;
		for (int oy = -r; oy <= r; oy++) begin
			for (int ox = -r; ox <= r; ox++) begin
				px = cx + ox;
				py = cy + oy;
				if (ox*ox + oy*oy <= r*r && px >= 0 && px < act_w && py >= 0 && py < act_h)
					shadow_img[py*act_w + px] = val;
			end
		end
	endtask

	task automatic paint_segment(logic [7:0] sx, logic [7:0] sy, logic [7:0] ex,
			logic [7:0] ey, logic [3:0] rad, logic [7:0] val);
		int x0, y0, x1, y1, dx, dy, adx, ady, steps, r, px, py;
		x0 = edge_clamp(sx, act_w);
		y0 = edge_clamp(sy, act_h);
		x1 = edge_clamp(ex, act_w);
		y1 = edge_clamp(ey, act_h);
		dx = x1 - x0;
		dy = y1 - y0;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		steps = adx > ady ? adx : ady;
		r = int'(rad);
		if (r > MAXR) r = MAXR;
		for (int s = 0; s <= steps; s++) begin
			// SV signed division truncates toward zero
			px = steps > 0 ? x0 + (s*dx) / steps : x0;
			py = steps > 0 ? y0 + (s*dy) / steps : y0;
			stamp_disc(px, py, r, val);
		end
	endtask

	// Advance the shadow raster by one accepted command
	task automatic predict_command(logic [1:0] c, logic [7:0] sx, logic [7:0] sy,
			logic [7:0] ex, logic [7:0] ey, logic [3:0] rad, logic [7:0] val);
		case (c)
			tlcs_pkg::CMD_DRAW: begin
				paint_segment(sx, sy, ex, ey, rad, val);
			end
			tlcs_pkg::CMD_READ: begin
				if (int'(sx) < act_w && int'(sy) < act_h)
					expect_pixel(shadow_img[int'(sy)*act_w + int'(sx)]);
				else
					expect_pixel(8'd0);
			end
			tlcs_pkg::CMD_CLEAR: begin
				wipe_shadow();
			end
			default: begin
			end
		endcase
	endtask

	// Offer one command beat; hold it until taken
	task automatic send_cmd(logic [1:0] c, logic [7:0] sx, logic [7:0] sy,
			logic [7:0] ex, logic [7:0] ey, logic [3:0] rad, logic [7:0] val);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_gap_pct) gap = $urandom_range(6, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		brush_radius <= rad;
		paint_value <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_command(c, sx, sy, ex, ey, rad, val);
	endtask

	task automatic read_px(int x, int y);
		send_cmd(tlcs_pkg::CMD_READ, x[7:0], y[7:0], 8'($urandom), 8'($urandom),
			4'($urandom), 8'($urandom));
	endtask

	// Drain: every read answered, then the block back to taking commands
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (in_stall) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == tlcs_pkg::REG_WIDTH) act_w = fit_dim(val, MAXW);
		else if (idx == tlcs_pkg::REG_HEIGHT) act_h = fit_dim(val, MAXH);
	endtask

	task automatic set_raster(logic [8:0] w, logic [8:0] h);
		wait_idle();
		write_reg(tlcs_pkg::REG_WIDTH, w);
		write_reg(tlcs_pkg::REG_HEIGHT, h);
	endtask

	// Full-size raster: disc clipping at the corner, widest radius, steep walk
	task automatic test_full_raster_draws();
		send_cmd(tlcs_pkg::CMD_DRAW, 8'd128, 8'd128, 8'd128, 8'd128, 4'd0, 8'hFF);
		read_px(128, 128);
		read_px(129, 128);
		send_cmd(tlcs_pkg::CMD_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 4'd15, 8'hA5);
		read_px(15, 0);
		read_px(16, 0);
		read_px(10, 10);
		read_px(11, 11);
		send_cmd(tlcs_pkg::CMD_DRAW, 8'd200, 8'd10, 8'd190, 8'd40, 4'd0, 8'h5A);
		read_px(197, 19);
		send_cmd(tlcs_pkg::CMD_DRAW, 8'd40, 8'd250, 8'd60, 8'd250, 4'd8, 8'h81);
		read_px(50, 242);
		read_px(255, 255);
	endtask

	// Tiny raster: clamped endpoints, reads outside, unused command, clear
	task automatic test_clamp_and_clear();
		set_raster(9'd10, 9'd8);
		send_cmd(tlcs_pkg::CMD_DRAW, 8'd255, 8'd255, 8'd0, 8'd255, 4'd1, 8'h3C);
		read_px(9, 7);
		read_px(10, 7);
		read_px(9, 8);
		send_cmd(CMD_SPARE, 8'd9, 8'd7, 8'd0, 8'd0, 4'd0, 8'h00);
		read_px(9, 7);
		send_cmd(tlcs_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 8'h00);
		read_px(9, 7);
	endtask

	// Layout change leaves the store alone; out-of-range register values
	task automatic test_register_extremes();
		send_cmd(tlcs_pkg::CMD_DRAW, 8'd3, 8'd2, 8'd3, 8'd2, 4'd0, 8'h77);
		set_raster(9'd5, 9'd8);
		read_px(3, 4);
		read_px(3, 2);
		set_raster(9'd0, 9'd0);
		wait_idle();
		write_reg(REG_SPARE, 9'd3);
		send_cmd(tlcs_pkg::CMD_DRAW, 8'd200, 8'd100, 8'd0, 8'd0, 4'd15, 8'h11);
		read_px(0, 0);
		read_px(1, 0);
		set_raster(9'd511, 9'd300);
		read_px(0, 0);
		read_px(255, 255);
	endtask

	// Mostly draws and nearby reads with random content, plus a little noise
	task automatic test_random_mix(int n, int rmax);
		int sel, rad, x, y;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 55) begin
				rad = $urandom_range(rmax);
				if (act_w*act_h <= 1200 && $urandom_range(99) < 4) rad = $urandom_range(15, 8);
				last_x = $urandom_range(255);
				last_y = $urandom_range(255);
				if ($urandom_range(1)) begin
					last_x = $urandom_range(act_w - 1);
					last_y = $urandom_range(act_h - 1);
				end
				send_cmd(tlcs_pkg::CMD_DRAW, last_x[7:0], last_y[7:0], 8'($urandom),
					8'($urandom), rad[3:0], 8'($urandom));
			end else if (sel < 92) begin
				if (sel < 80) begin
					x = edge_clamp(last_x[7:0], act_w) + $urandom_range(4) - 2;
					y = edge_clamp(last_y[7:0], act_h) + $urandom_range(4) - 2;
					if (x < 0) x = 0;
					if (y < 0) y = 0;
				end else begin
					x = $urandom_range(255);
					y = $urandom_range(255);
				end
				read_px(x, y);
			end else if (sel < 98) begin
				send_cmd(CMD_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					4'($urandom), 8'($urandom));
			end else if (sel == 98) begin
				send_cmd(tlcs_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 4'($urandom), 8'($urandom));
			end else begin
				read_px($urandom_range(255), $urandom_range(255));
			end
		end
	endtask

	// Hold the receiver off while reads keep coming, so the block backs up
	task automatic test_output_backpressure();
		wait_idle();
		send_cmd(tlcs_pkg::CMD_DRAW, 8'd2, 8'd2, 8'd12, 8'd9, 4'd2, 8'hC3);
		hold_req = 400;
		for (int i = 0; i < 10; i++) read_px(2 + i, 2 + (i % 8));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = tlcs_pkg::CMD_DRAW;
		start_x = 8'd0;
		start_y = 8'd0;
		end_x = 8'd0;
		end_y = 8'd0;
		brush_radius = 4'd0;
		paint_value = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = tlcs_pkg::REG_WIDTH;
		cfg_data = 9'd0;
		out_stall = 1'b0;
		fail_cnt = 0;
		cycle_cnt = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		last_x = 0;
		last_y = 0;
		act_w = MAXW;
		act_h = MAXH;
		wipe_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_full_raster_draws();
		test_clamp_and_clear();
		test_register_extremes();

		set_raster(9'd24, 9'd20);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_mix(75, 3);

		set_raster(9'd256, 9'd1);
		send_gap_pct = 45;
		recv_stall_pct = 0;
		test_random_mix(75, 2);

		set_raster(9'd1, 9'd256);
		send_gap_pct = 0;
		recv_stall_pct = 45;
		test_random_mix(75, 2);

		set_raster(9'd40, 9'd30);
		send_gap_pct = 8;
		recv_stall_pct = 8;
		test_random_mix(75, 3);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_output_backpressure();

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0 && pending_pixels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
